FILE: hw/rtl/pse_pkg.sv
// Shared types, constants and helpers for the printable string extractor.
// Used by pse_ctrl, pse_datapath and printable_string_extractor_top.
`timescale 1ns / 1ps

package pse_pkg;

    localparam int HOLD_DEPTH_DEF = 32;
    localparam int MAX_KEEP_DEF   = 1022;

    localparam int BYTE_W     = 8;
    localparam int MIN_LEN_W  = 6;
    localparam int OFFSET_W   = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = BYTE_W + OFFSET_W;

    localparam logic [BYTE_W-1:0]    CHAR_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0]    CHAR_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0]    CHAR_DEL       = 8'h7F;
    localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RST = 6'd4;
    localparam logic [OFFSET_W-1:0]  BASE_OFFSET_RST = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LENGTH  = 1'b0,
        CFG_BASE_OFFSET = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_CLOSE,
        ST_FLUSH_RD,
        ST_FLUSH_EM,
        ST_TERM,
        ST_POST,
        ST_DONE
    } pse_state_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic emit_byte;
        logic flush_start;
        logic flush_read;
        logic flush_emit;
        logic set_stream;
        logic term_emit;
        logic clear_run;
        logic pos_reload;
        logic push_last;
    } pse_cmd_t;

    typedef struct packed {
        logic printable;
        logic streaming;
        logic kept_zero;
        logic keep_room;
        logic hold_reach;
        logic close_reach;
        logic flush_last;
        logic emit_ok;
        logic out_free;
        logic pend_valid;
        logic last_flag;
    } pse_status_t;

    function automatic logic is_printable(input logic [BYTE_W-1:0] b);
        return (b == CHAR_TAB) || ((b >= CHAR_SPACE) && (b < CHAR_DEL));
    endfunction

endpackage

FILE: hw/rtl/printable_string_extractor_top.sv
// Top level of the printable string extractor: joins pse_ctrl and
// pse_datapath. Depends on pse_pkg.
//
//   channel | dir | beat contents
//   s_      | in  | tdata[7:0] data byte, tlast region end
//   m_      | out | tdata[7:0] text byte, tdata[39:8] string offset,
//           |     | tuser terminator flag, tlast last result of the input byte
//   cfg_    | in  | index 0 min length, index 1 base offset
//
// Each byte passes through the step, post and done states; a non-printable
// byte adds the close state, and region end adds a closing pass. A byte
// streamed through can be held by output stalls. A flush reads each held byte
// from the registered hold buffer before emitting it; a terminator is one more emit.
// Reset is synchronous, active low; min length returns to 4, base offset to 0.
// A stall on m_ holds the sequencer at its next emit; s_tready is high only
// between items.
`timescale 1ns / 1ps

module printable_string_extractor_top import pse_pkg::*; #(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
    parameter int MAX_KEEP   = MAX_KEEP_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,    // [7:0] data_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // [7:0] text_byte, [39:8] string_offset
    output logic                  m_tuser,    // [0] is_terminator
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pse_cmd_t    cmd;
    pse_status_t status;

    assign cfg_ready = 1'b1;

    pse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pse_datapath #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .MAX_KEEP   (MAX_KEEP)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_byte || cmd.flush_emit || cmd.term_emit) |-> status.emit_ok)
        else $error("emit without room in pending stage");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second byte taken while one is in work");

    a_push_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_last |=> (m_tvalid && m_tlast))
        else $error("final result not presented with tlast");

endmodule

FILE: hw/rtl/pse_ctrl.sv
// Sequencer of the printable string extractor: steps each byte through
// hold, flush, close and terminator phases. Depends on pse_pkg.
`timescale 1ns / 1ps

module pse_ctrl import pse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  pse_status_t status,
    output pse_cmd_t    cmd
);

    pse_state_t state_reg, state_next;
    logic       ret_term_reg, ret_term_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_term_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_term_reg <= ret_term_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        ret_term_next = ret_term_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (!(status.printable && status.streaming && status.keep_room)
                    || status.emit_ok) begin
                    cmd.step      = 1'b1;
                    cmd.emit_byte = status.printable && status.streaming && status.keep_room;
                    if (!status.printable) begin
                        state_next = ST_CLOSE;
                    end else if (!status.streaming && status.hold_reach) begin
                        cmd.flush_start = 1'b1;
                        ret_term_next   = 1'b0;
                        state_next      = ST_FLUSH_RD;
                    end else begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_CLOSE: begin
                if (!status.kept_zero && !status.streaming && status.close_reach) begin
                    cmd.flush_start = 1'b1;
                    ret_term_next   = 1'b1;
                    state_next      = ST_FLUSH_RD;
                end else if (status.streaming) begin
                    state_next = ST_TERM;
                end else begin
                    cmd.clear_run = 1'b1;
                    state_next    = ST_POST;
                end
            end
            ST_FLUSH_RD: begin
                cmd.flush_read = 1'b1;
                state_next     = ST_FLUSH_EM;
            end
            ST_FLUSH_EM: begin
                if (status.emit_ok) begin
                    cmd.flush_emit = 1'b1;
                    if (status.flush_last) begin
                        cmd.set_stream = 1'b1;
                        state_next     = ret_term_reg ? ST_TERM : ST_POST;
                    end else begin
                        state_next = ST_FLUSH_RD;
                    end
                end
            end
            ST_TERM: begin
                if (status.emit_ok) begin
                    cmd.term_emit = 1'b1;
                    cmd.clear_run = 1'b1;
                    state_next    = ST_POST;
                end
            end
            ST_POST: begin
                if (status.last_flag) begin
                    cmd.pos_reload = 1'b1;
                    state_next     = ST_CLOSE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!status.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.push_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/pse_datapath.sv
// Datapath of the printable string extractor: hold buffer, run counters,
// offsets, config registers, pending result and output register. Uses pse_pkg.
`timescale 1ns / 1ps

module pse_datapath import pse_pkg::*; #(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF,
    parameter int MAX_KEEP   = MAX_KEEP_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [BYTE_W-1:0]     s_tdata,
    input  logic                  s_tlast,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  pse_cmd_t              cmd,
    output pse_status_t           status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int KEEP_MAX = (HOLD_DEPTH > MAX_KEEP) ? HOLD_DEPTH : MAX_KEEP;
    localparam int KEEP_W   = $clog2(KEEP_MAX + 1);
    localparam int ADDR_W   = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int LIMIT    = (HOLD_DEPTH < MAX_KEEP) ? HOLD_DEPTH : MAX_KEEP;

    localparam logic [KEEP_W-1:0] HOLD_K  = KEEP_W'(HOLD_DEPTH);
    localparam logic [KEEP_W-1:0] MAXK_K  = KEEP_W'(MAX_KEEP);
    localparam logic [KEEP_W-1:0] LIMIT_K = KEEP_W'(LIMIT);
    localparam logic [KEEP_W-1:0] ONE_K   = KEEP_W'(1);

    logic [BYTE_W-1:0]    hold_mem [HOLD_DEPTH];
    logic [BYTE_W-1:0]    byte_reg;
    logic                 last_reg;
    logic [KEEP_W-1:0]    kept_reg;
    logic                 stream_reg;
    logic [OFFSET_W-1:0]  pos_reg;
    logic [OFFSET_W-1:0]  start_reg;
    logic [MIN_LEN_W-1:0] min_len_reg;
    logic [OFFSET_W-1:0]  base_reg;
    logic [KEEP_W-1:0]    idx_reg;
    logic [BYTE_W-1:0]    rd_data_reg;
    logic                 pend_valid_reg;
    logic                 pend_term_reg;
    logic [BYTE_W-1:0]    pend_byte_reg;
    logic [OFFSET_W-1:0]  pend_offset_reg;
    logic                 out_valid_reg;
    logic                 out_term_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [OFFSET_W-1:0]  out_offset_reg;
    logic                 out_last_reg;

    logic [KEEP_W-1:0] eff_min;
    logic [KEEP_W-1:0] kept_inc;
    logic              hold_room;
    logic              printable;
    logic              emit;
    logic              load_out;
    logic [BYTE_W-1:0] emit_byte;
    logic              hold_wr;

    always_comb begin
        eff_min = KEEP_W'(min_len_reg);
        if (min_len_reg == '0) begin
            eff_min = ONE_K;
        end else if (eff_min > LIMIT_K) begin
            eff_min = LIMIT_K;
        end
    end

    assign printable = is_printable(byte_reg);
    assign hold_room = kept_reg < HOLD_K;
    assign kept_inc  = hold_room ? kept_reg + ONE_K : kept_reg;
    assign hold_wr   = cmd.step && printable && !stream_reg && hold_room;
    assign emit      = cmd.emit_byte || cmd.flush_emit || cmd.term_emit;
    assign load_out  = (emit && pend_valid_reg) || cmd.push_last;

    always_comb begin
        emit_byte = '0;
        if (cmd.emit_byte) begin
            emit_byte = byte_reg;
        end else if (cmd.flush_emit) begin
            emit_byte = rd_data_reg;
        end
    end

    always_comb begin
        status.printable   = printable;
        status.streaming   = stream_reg;
        status.kept_zero   = kept_reg == '0;
        status.keep_room   = kept_reg < MAXK_K;
        status.hold_reach  = kept_inc >= eff_min;
        status.close_reach = kept_reg >= eff_min;
        status.flush_last  = (idx_reg + ONE_K) == kept_reg;
        status.out_free    = !out_valid_reg || m_tready;
        status.emit_ok     = !pend_valid_reg || status.out_free;
        status.pend_valid  = pend_valid_reg;
        status.last_flag   = last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg       <= 1'b0;
            kept_reg       <= '0;
            stream_reg     <= 1'b0;
            pos_reg        <= BASE_OFFSET_RST;
            start_reg      <= '0;
            min_len_reg    <= MIN_LENGTH_RST;
            base_reg       <= BASE_OFFSET_RST;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_MIN_LENGTH: begin
                        min_len_reg <= cfg_data[MIN_LEN_W-1:0];
                    end
                    CFG_BASE_OFFSET: begin
                        base_reg <= cfg_data[OFFSET_W-1:0];
                        pos_reg  <= cfg_data[OFFSET_W-1:0];
                    end
                endcase
            end
            if (cmd.accept) begin
                last_reg <= s_tlast;
            end
            if (cmd.step) begin
                pos_reg <= pos_reg + OFFSET_W'(1);
                if (printable) begin
                    if (kept_reg == '0) begin
                        start_reg <= pos_reg;
                    end
                    if (stream_reg) begin
                        if (kept_reg < MAXK_K) begin
                            kept_reg <= kept_reg + ONE_K;
                        end
                    end else begin
                        kept_reg <= kept_inc;
                    end
                end
            end
            if (cmd.set_stream) begin
                stream_reg <= 1'b1;
            end
            if (cmd.clear_run) begin
                kept_reg   <= '0;
                stream_reg <= 1'b0;
            end
            if (cmd.pos_reload) begin
                pos_reg  <= base_reg;
                last_reg <= 1'b0;
            end
            if (emit) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.push_last) begin
                pend_valid_reg <= 1'b0;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_tdata;
        end
        if (hold_wr) begin
            hold_mem[kept_reg[ADDR_W-1:0]] <= byte_reg;
        end
        if (cmd.flush_read) begin
            rd_data_reg <= hold_mem[idx_reg[ADDR_W-1:0]];
        end
        if (cmd.flush_start) begin
            idx_reg <= '0;
        end else if (cmd.flush_emit) begin
            idx_reg <= idx_reg + ONE_K;
        end
        if (load_out) begin
            out_term_reg   <= pend_term_reg;
            out_byte_reg   <= pend_byte_reg;
            out_offset_reg <= pend_offset_reg;
            out_last_reg   <= cmd.push_last;
        end
        if (emit) begin
            pend_term_reg   <= cmd.term_emit;
            pend_byte_reg   <= emit_byte;
            pend_offset_reg <= start_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_offset_reg, out_byte_reg};
    assign m_tuser  = out_term_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: bench/pse_string_check.sv
`timescale 1ns / 1ps
// Result checker for the printable string extractor: watches the byte, result
// and register channels, predicts every result beat and compares it in order.
// Depends on pse_pkg.

module pse_string_check import pse_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    expected_left
);

    typedef struct {
        logic                term;
        logic [BYTE_W-1:0]   text;
        logic [OFFSET_W-1:0] offset;
        logic                last;
    } string_beat_t;

    logic [BYTE_W-1:0]    held_bytes [HOLD_DEPTH_DEF];
    int unsigned          run_len;
    logic [OFFSET_W-1:0]  scan_pos;
    logic [OFFSET_W-1:0]  run_base;
    logic                 reported;
    logic [MIN_LEN_W-1:0] min_len;
    logic [OFFSET_W-1:0]  region_base;
    string_beat_t         expected_beats[$];
    string_beat_t         want;
    int                   mismatches = 0;

    function automatic int unsigned report_threshold();
        int unsigned m;
        m = int'(min_len);
        if (m < 1) m = 1;
        if (m > HOLD_DEPTH_DEF) m = HOLD_DEPTH_DEF;
        if (m > MAX_KEEP_DEF) m = MAX_KEEP_DEF;
        return m;
    endfunction

    function automatic void add_beat(input logic term, input logic [BYTE_W-1:0] b);
        string_beat_t r;
        r.term   = term;
        r.text   = term ? '0 : b;
        r.offset = run_base;
        r.last   = 1'b0;
        expected_beats.push_back(r);
    endfunction

    function automatic void release_held();
        for (int unsigned i = 0; i < run_len && i < HOLD_DEPTH_DEF; i++) begin
            add_beat(1'b0, held_bytes[i]);
        end
        reported = 1'b1;
    endfunction

    function automatic void close_run();
        if (run_len > 0) begin
            if (!reported && run_len >= report_threshold()) release_held();
            if (reported) add_beat(1'b1, '0);
        end
        run_len  = 0;
        reported = 1'b0;
    endfunction

    function automatic void scan_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int           beats_prior;
        string_beat_t tail;
        beats_prior = expected_beats.size();
        if (b == CHAR_TAB || (b >= CHAR_SPACE && b < CHAR_DEL)) begin
            if (run_len == 0) begin
                run_base = scan_pos;
                reported = 1'b0;
            end
            if (reported) begin
                if (run_len < MAX_KEEP_DEF) begin
                    add_beat(1'b0, b);
                    run_len++;
                end
            end else begin
                if (run_len < HOLD_DEPTH_DEF) begin
                    held_bytes[run_len] = b;
                    run_len++;
                end
                if (run_len >= report_threshold()) release_held();
            end
        end else begin
            close_run();
        end
        scan_pos = scan_pos + 1;
        if (fin) begin
            close_run();
            scan_pos = region_base;
        end
        // mark the final beat of this byte
        if (expected_beats.size() > beats_prior) begin
            tail = expected_beats.pop_back();
            tail.last = 1'b1;
            expected_beats.push_back(tail);
        end
    endfunction

    function automatic void note_failure();
        mismatches++;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            run_len     = 0;
            run_base    = '0;
            reported    = 1'b0;
            min_len     = MIN_LENGTH_RST;
            region_base = BASE_OFFSET_RST;
            scan_pos    = BASE_OFFSET_RST;
            expected_beats.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MIN_LENGTH) begin
                    min_len = cfg_data[MIN_LEN_W-1:0];
                end else begin
                    region_base = cfg_data[OFFSET_W-1:0];
                    scan_pos    = cfg_data[OFFSET_W-1:0];
                end
            end
            if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_beats.size() == 0) begin
                    note_failure();
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat term=%0b byte=%02h off=%08h last=%0b",
                                 $realtime, m_tuser, m_tdata[BYTE_W-1:0],
                                 m_tdata[BYTE_W +: OFFSET_W], m_tlast);
                end else begin
                    want = expected_beats.pop_front();
                    if (m_tuser !== want.term || m_tdata[BYTE_W-1:0] !== want.text ||
                        m_tdata[BYTE_W +: OFFSET_W] !== want.offset || m_tlast !== want.last) begin
                        note_failure();
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected term=%0b byte=%02h off=%08h last=%0b",
                                     want.term, want.text, want.offset, want.last);
                            $display("  actual   term=%0b byte=%02h off=%08h last=%0b",
                                     m_tuser, m_tdata[BYTE_W-1:0],
                                     m_tdata[BYTE_W +: OFFSET_W], m_tlast);
                        end
                    end
                end
            end
        end
        fail_count    <= mismatches;
        expected_left <= expected_beats.size();
    end

endmodule

FILE: bench/printable_string_extractor_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the printable string extractor: clock, reset, byte and
// register stimulus, receiver backpressure, watchdog and verdict.
// Depends on pse_pkg, printable_string_extractor_top and pse_string_check.

module printable_string_extractor_top_test;
    import pse_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 12;
    localparam int TAIL_CYCLES     = 20;
    localparam int LONG_RUN        = 34;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int expected_left;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_asked   = 0;
    int holds_done    = 0;
    int stall_cycles  = 0;
    int items_sent    = 0;

    printable_string_extractor_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pse_string_check i_string_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (holds_done != holds_asked) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge aclk);
                holds_done++;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [BYTE_W-1:0] rand_text_byte();
        if ($urandom_range(7) == 0) return CHAR_TAB;
        return BYTE_W'($urandom_range(CHAR_SPACE, CHAR_DEL - 1));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_separator();
        case ($urandom_range(3))
            0: return CHAR_NEWLINE;
            1: return BYTE_W'($urandom_range(0, CHAR_TAB - 1));
            2: return BYTE_W'($urandom_range(CHAR_NEWLINE, CHAR_SPACE - 1));
            default: return BYTE_W'($urandom_range(CHAR_DEL, 255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_min();
        case ($urandom_range(7))
            0: return 0;
            1: return 1;
            2: return HOLD_DEPTH_DEF;
            3: return $urandom_range(HOLD_DEPTH_DEF + 1, 63);
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_text(input string txt, input logic end_on_last);
        for (int i = 0; i < txt.len(); i++) begin
            send_beat(txt[i], end_on_last && (i == txt.len() - 1));
        end
    endtask

    // hold the sender until every predicted beat has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_segment();
        int unsigned kind;
        int unsigned len;
        logic        end_on_text;
        kind = $urandom_range(19);
        if (kind < 14) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            end_on_text = ($urandom_range(5) == 0);
            for (int unsigned i = 0; i < len; i++) begin
                send_beat(rand_text_byte(), end_on_text && (i == len - 1));
            end
            if (!end_on_text) send_beat(rand_separator(), $urandom_range(5) == 0);
        end else if (kind < 17) begin
            repeat ($urandom_range(1, 4))
                send_beat(BYTE_W'($urandom_range(255)), $urandom_range(9) == 0);
        end else if (kind == 17) begin
            repeat ($urandom_range(1, 3)) send_beat(rand_text_byte(), 1'b0);
            write_reg(CFG_MIN_LENGTH, pick_min());
        end else begin
            write_reg(CFG_BASE_OFFSET, $urandom());
        end
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct, input int count);
        int target;
        settle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_reg(CFG_MIN_LENGTH, pick_min());
        write_reg(CFG_BASE_OFFSET, $urandom());
        target = items_sent + count;
        while (items_sent < target) random_segment();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 36;
        recv_idle_pct = 53;

        // reset settings: min length 4, base offset 0
        send_text("ab\n", 1'b0);
        send_text(" ~\tx", 1'b0);
        send_beat("y", 1'b0);
        send_beat(CHAR_DEL, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h1F, 1'b0);
        send_text("PQRS", 1'b1);
        send_beat("k", 1'b0);
        send_beat(8'h80, 1'b1);

        write_reg(CFG_MIN_LENGTH, 0);
        send_beat("z", 1'b0);
        send_beat(8'h0D, 1'b0);
        send_text("q", 1'b1);

        write_reg(CFG_MIN_LENGTH, 63);
        repeat (HOLD_DEPTH_DEF + 1) send_beat(rand_text_byte(), 1'b0);
        send_beat(CHAR_NEWLINE, 1'b1);

        // change the threshold while a run is held or streaming
        write_reg(CFG_MIN_LENGTH, 8);
        send_text("abc", 1'b0);
        write_reg(CFG_MIN_LENGTH, 2);
        send_beat("d", 1'b0);
        write_reg(CFG_MIN_LENGTH, 40);
        send_beat("e", 1'b0);
        send_beat(CHAR_NEWLINE, 1'b0);
        write_reg(CFG_MIN_LENGTH, 8);
        send_text("abc", 1'b0);
        write_reg(CFG_MIN_LENGTH, 3);
        send_beat(CHAR_NEWLINE, 1'b0);

        // offset wrap and region reload
        write_reg(CFG_BASE_OFFSET, 32'hFFFF_FFFF);
        send_text("wxyz\n", 1'b0);
        send_text("uvw", 1'b1);
        send_text("\001rst", 1'b1);

        // run longer than the hold buffer
        write_reg(CFG_MIN_LENGTH, 1);
        write_reg(CFG_BASE_OFFSET, 0);
        repeat (LONG_RUN) send_beat(rand_text_byte(), 1'b0);
        send_beat(CHAR_NEWLINE, 1'b0);

        random_phase(36, 53, 8);
        random_phase(53, 36, 8);

        // long receiver hold-off while every byte produces a beat
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_MIN_LENGTH, 1);
        holds_asked++;
        repeat (20) send_beat(rand_text_byte(), 1'b0);
        send_beat(CHAR_NEWLINE, 1'b0);

        random_phase(0, 0, 8);

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_left == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: printable_string_extractor_top.f
hw/rtl/pse_pkg.sv
hw/rtl/pse_ctrl.sv
hw/rtl/pse_datapath.sv
hw/rtl/printable_string_extractor_top.sv
bench/pse_string_check.sv
bench/printable_string_extractor_top_test.sv
